// ===== hdl/radius_neighbor_detector_macros.svh =====
// assertion macros for the radius neighbor detector
`ifndef RADIUS_NEIGHBOR_DETECTOR_MACROS_SVH
`define RADIUS_NEIGHBOR_DETECTOR_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, disabled while in reset
`define RND_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
// next-cycle implication, disabled while in reset
`define RND_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define RND_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RND_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/rnd_pkg.sv =====
// shared constants and beat types for the radius neighbor detector
`timescale 1ns / 1ps
package rnd_pkg;

    localparam int MAX_AGENTS = 32;
    localparam int COORD_BITS = 16;

    localparam int FIELD_W  = 16;
    localparam int AIDX_W   = 5;
    localparam int MASK_W   = 32;
    localparam int R2_W     = 2 * FIELD_W;
    localparam int IDX_W    = $clog2(MAX_AGENTS + 1);
    localparam int SQ_W     = 2 * COORD_BITS;
    localparam int CMP_W    = (SQ_W + 1 > R2_W) ? SQ_W + 1 : R2_W;

    typedef struct packed {
        logic                      frame_start;
        logic signed [FIELD_W-1:0] pos_x;
        logic signed [FIELD_W-1:0] pos_y;
        logic        [FIELD_W-1:0] comm_range;
    } t_in_beat;

    typedef struct packed {
        logic [AIDX_W-1:0] agent_index;
        logic [MASK_W-1:0] neighbor_mask;
        logic              full_res;
    } t_out_beat;

    // query travelling down the chain one cell per cycle while the chain advances
    typedef struct packed {
        logic                         vld;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic        [R2_W-1:0]       r2;
        logic        [IDX_W-1:0]      idx;
        logic                         full;
    } t_hdr;

    // neighbor mask wave that trails its query down the chain
    typedef struct packed {
        logic              vld;
        logic [IDX_W-1:0]  idx;
        logic              full;
        logic [MASK_W-1:0] mask;
    } t_msk;

endpackage

// ===== hdl/radius_neighbor_detector.sv =====
// top level: agent intake, chain of position slots and result register
`timescale 1ns / 1ps
`include "radius_neighbor_detector_macros.svh"
// Agents enter one beat per cycle while o_in_ready is high and each yields one
// result beat, in order. Every agent is queried against a row of MAX_AGENTS
// slots; the query moves one slot per cycle while the row advances, and the
// neighbor mask follows behind it (difference, square, compare), so an agent
// stored in its slot is already visible to the agent right after it. The only
// thing that slows intake is the result register: while a result waits and
// i_out_ready is low the whole row holds and o_in_ready drops. After reset the
// slots hold no agents; a beat with frame_start set restarts indexing at zero.
module radius_neighbor_detector (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rnd_pkg::t_in_beat   i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rnd_pkg::t_out_beat  o_out_beat
);

    localparam int M  = rnd_pkg::MAX_AGENTS;
    localparam int CB = rnd_pkg::COORD_BITS;

    logic [rnd_pkg::IDX_W-1:0]  r_count;
    logic [rnd_pkg::IDX_W-1:0]  n_count;
    rnd_pkg::t_hdr              r_hdr;
    rnd_pkg::t_msk              r_seed_a;
    rnd_pkg::t_msk              r_seed_b;
    logic                       r_out_valid;
    rnd_pkg::t_out_beat         r_out;

    logic                       w_adv;
    logic                       w_acc;
    logic [rnd_pkg::IDX_W-1:0]  w_start;
    logic                       w_full;
    logic [rnd_pkg::R2_W-1:0]   w_r2;
    logic [rnd_pkg::FIELD_W-1:0] w_raw_x;
    logic [rnd_pkg::FIELD_W-1:0] w_raw_y;

    rnd_pkg::t_hdr              w_hdr [M+1];
    rnd_pkg::t_msk              w_msk [M+1];

    assign w_adv = !r_out_valid || i_out_ready;
    assign w_acc = i_in_valid && w_adv;

    always_comb begin
        w_start = i_in_beat.frame_start ? '0 : r_count;
        w_full  = (w_start == rnd_pkg::IDX_W'(M));
        n_count = w_full ? w_start : w_start + 1'b1;
        w_raw_x = i_in_beat.pos_x;
        w_raw_y = i_in_beat.pos_y;
    end

    assign w_r2 = i_in_beat.comm_range * i_in_beat.comm_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_hdr.vld    <= 1'b0;
            r_seed_a.vld <= 1'b0;
            r_seed_b.vld <= 1'b0;
            r_out_valid  <= 1'b0;
        end else if (w_adv) begin
            if (w_acc) begin
                r_count <= n_count;
            end
            r_hdr.vld    <= w_acc;
            r_seed_a.vld <= r_hdr.vld;
            r_seed_b.vld <= r_seed_a.vld;
            r_out_valid  <= w_msk[M].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // coordinates are the low coord bits of the field, zero-extended if wider
            r_hdr.x    <= signed'(CB'(w_raw_x));
            r_hdr.y    <= signed'(CB'(w_raw_y));
            r_hdr.r2   <= w_r2;
            r_hdr.idx  <= w_start;
            r_hdr.full <= w_full;
            r_seed_a.idx  <= r_hdr.idx;
            r_seed_a.full <= r_hdr.full;
            r_seed_a.mask <= '0;
            r_seed_b.idx  <= r_seed_a.idx;
            r_seed_b.full <= r_seed_a.full;
            r_seed_b.mask <= r_seed_a.mask;
            r_out.agent_index   <= w_msk[M].full ? '0 : rnd_pkg::AIDX_W'(w_msk[M].idx);
            r_out.neighbor_mask <= w_msk[M].mask;
            r_out.full_res      <= w_msk[M].full;
        end
    end

    assign w_hdr[0] = r_hdr;
    assign w_msk[0] = r_seed_b;

    for (genvar k = 0; k < M; k++) begin : g_cell
        rnd_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_adv      (w_adv),
            .i_cell_idx (rnd_pkg::IDX_W'(k)),
            .i_hdr      (w_hdr[k]),
            .o_hdr      (w_hdr[k+1]),
            .i_msk      (w_msk[k]),
            .o_msk      (w_msk[k+1])
        );
    end

    assign o_in_ready  = w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    `RND_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= rnd_pkg::IDX_W'(M))
    `RND_ASSERT_NXT(a_frame_restart, i_clk, i_rst_n, w_acc && i_in_beat.frame_start, r_hdr.vld && (r_hdr.idx == '0) && !r_hdr.full)
    `RND_ASSERT_NXT(a_chain_holds, i_clk, i_rst_n, !w_adv, $stable(w_hdr[M]) && $stable(w_msk[M]))

endmodule

// ===== hdl/rnd_cell.sv =====
// one agent slot: stores a position and tests passing queries against it
`timescale 1ns / 1ps
module rnd_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic [rnd_pkg::IDX_W-1:0]     i_cell_idx,
    input  rnd_pkg::t_hdr                 i_hdr,
    output rnd_pkg::t_hdr                 o_hdr,
    input  rnd_pkg::t_msk                 i_msk,
    output rnd_pkg::t_msk                 o_msk
);

    localparam int CB = rnd_pkg::COORD_BITS;

    rnd_pkg::t_hdr                  r_hdr;
    rnd_pkg::t_msk                  r_msk;
    logic signed [CB-1:0]           r_st_x;
    logic signed [CB-1:0]           r_st_y;
    logic [CB-1:0]                  r_dx;
    logic [CB-1:0]                  r_dy;
    logic [rnd_pkg::R2_W-1:0]       r_r2_a;
    logic                           r_en_a;
    logic [rnd_pkg::SQ_W-1:0]       r_sx;
    logic [rnd_pkg::SQ_W-1:0]       r_sy;
    logic [rnd_pkg::R2_W-1:0]       r_r2_b;
    logic                           r_en_b;

    logic signed [CB:0]             w_diff_x;
    logic signed [CB:0]             w_diff_y;
    logic [CB-1:0]                  n_dx;
    logic [CB-1:0]                  n_dy;
    logic                           n_en;
    logic [rnd_pkg::SQ_W-1:0]       w_sqx;
    logic [rnd_pkg::SQ_W-1:0]       w_sqy;
    logic [rnd_pkg::CMP_W-1:0]      w_sum;
    logic                           w_hit;
    logic [rnd_pkg::MASK_W-1:0]     w_bit;
    logic                           w_store;

    always_comb begin
        w_diff_x = {i_hdr.x[CB-1], i_hdr.x} - {r_st_x[CB-1], r_st_x};
        w_diff_y = {i_hdr.y[CB-1], i_hdr.y} - {r_st_y[CB-1], r_st_y};
        n_dx = w_diff_x[CB] ? CB'(-w_diff_x) : w_diff_x[CB-1:0];
        n_dy = w_diff_y[CB] ? CB'(-w_diff_y) : w_diff_y[CB-1:0];
        // only slots filled earlier in the frame take part
        n_en = i_hdr.vld && (i_cell_idx < i_hdr.idx);
        w_store = i_hdr.vld && !i_hdr.full && (i_hdr.idx == i_cell_idx);
    end

    assign w_sqx = r_dx * r_dx;
    assign w_sqy = r_dy * r_dy;
    assign w_sum = rnd_pkg::CMP_W'(r_sx) + rnd_pkg::CMP_W'(r_sy);
    assign w_hit = r_en_b && (w_sum < rnd_pkg::CMP_W'(r_r2_b));
    // slots past the mask width shift out to zero
    assign w_bit = w_hit ? (rnd_pkg::MASK_W'(1) << i_cell_idx) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr.vld <= 1'b0;
            r_msk.vld <= 1'b0;
            r_en_a    <= 1'b0;
            r_en_b    <= 1'b0;
        end else if (i_adv) begin
            r_hdr.vld <= i_hdr.vld;
            r_msk.vld <= i_msk.vld;
            r_en_a    <= n_en;
            r_en_b    <= r_en_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_hdr.x    <= i_hdr.x;
            r_hdr.y    <= i_hdr.y;
            r_hdr.r2   <= i_hdr.r2;
            r_hdr.idx  <= i_hdr.idx;
            r_hdr.full <= i_hdr.full;
            r_dx       <= n_dx;
            r_dy       <= n_dy;
            r_r2_a     <= i_hdr.r2;
            r_sx       <= w_sqx;
            r_sy       <= w_sqy;
            r_r2_b     <= r_r2_a;
            r_msk.idx  <= i_msk.idx;
            r_msk.full <= i_msk.full;
            r_msk.mask <= i_msk.mask | w_bit;
            if (w_store) begin
                r_st_x <= i_hdr.x;
                r_st_y <= i_hdr.y;
            end
        end
    end

    assign o_hdr = r_hdr;
    assign o_msk = r_msk;

endmodule
